### src/mapi_pkg.sv
// shared types, constants and the control-word table of the five-axis pi wrench controller
// depends on nothing; used by mapi_dp and multi_axis_pi_wrench_controller
`default_nettype none

package mapi_pkg;

  // sizing
  localparam int NUM_AXES   = 5;
  localparam int FRAC_BITS  = 16;
  localparam int AXIS_W     = 3;
  localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int DATA_W     = 32;
  localparam int DT_W       = 17;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
  localparam int STEP_W     = 4;
  localparam int ADDR_W     = 5;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  SAT_HI     = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  SAT_LO     = -SAT_HI - ACC_W'(1);

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X   = 3'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y   = 3'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z   = 3'd2;
  localparam logic [AXIS_W-1:0] AXIS_YAW = 3'd4;

  // register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_DT   = 3'd2;
  localparam logic [2:0] REG_OLG  = 3'd3;
  localparam logic [2:0] REG_BIAS = 3'd4;

  // reset values
  localparam logic [DATA_W-1:0] KP_RST   = 32'd65536000;
  localparam logic [DATA_W-1:0] KI_RST   = 32'd6553600;
  localparam logic [DT_W-1:0]   DT_RST   = 17'd655;
  localparam logic [DATA_W-1:0] OLG_RST  = 32'd65536;
  localparam logic [DATA_W-1:0] BIAS_RST = 32'd385745;

  // program steps
  localparam logic [STEP_W-1:0] ST_ERR     = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_EDT = 4'd1;
  localparam logic [STEP_W-1:0] ST_INTEG   = 4'd2;
  localparam logic [STEP_W-1:0] ST_ACC_LD  = 4'd3;
  localparam logic [STEP_W-1:0] ST_ACC_ADD = 4'd4;
  localparam logic [STEP_W-1:0] ST_DRV     = 4'd5;
  localparam logic [STEP_W-1:0] ST_SPD     = 4'd6;
  localparam logic [STEP_W-1:0] ST_SPD_LD  = 4'd7;
  localparam logic [STEP_W-1:0] ST_SPD_DRV = 4'd8;
  localparam logic [STEP_W-1:0] ST_DONE    = 4'd9;

  typedef enum logic [1:0] {
    MUL_ERR_DT,
    MUL_ERR_KP,
    MUL_INT_KI,
    MUL_SPD_OLG
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NO_POS,
    JMP_NO_SPD
  } jmp_e;

  typedef struct packed {
    mul_sel_e           mul_sel;
    logic               err_ld;
    logic               integ_wr;
    acc_op_e            acc_op;
    logic               drv_ld;
    logic               use_bias;
    jmp_e               jmp;
    logic [STEP_W-1:0]  jmp_tgt;
    logic               done;
  } ucode_t;

  typedef struct packed {
    logic [DATA_W-1:0] kp;
    logic [DATA_W-1:0] ki;
    logic [DT_W-1:0]   dt;
    logic [DATA_W-1:0] olg;
    logic [DATA_W-1:0] bias;
  } cfg_t;

  typedef struct packed {
    logic              pos_eff;
    logic              spd_eff;
    logic [AXIS_W-1:0] axis;
    logic [DATA_W-1:0] drive;
    logic              sat;
  } dp_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } clip_t;

  // clip to 32 bit signed, flag when clipped
  function automatic clip_t clip32(input logic signed [ACC_W-1:0] v);
    clip_t r;
    if (v > SAT_HI) begin
      r.val = 32'h7fff_ffff;
      r.sat = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '0;
    case (step)
      ST_ERR: begin
        u.err_ld  = 1'b1;
        u.jmp     = JMP_NO_POS;
        u.jmp_tgt = ST_SPD;
      end
      ST_MUL_EDT: begin
        u.mul_sel = MUL_ERR_DT;
      end
      ST_INTEG: begin
        u.integ_wr = 1'b1;
        u.mul_sel  = MUL_ERR_KP;
      end
      ST_ACC_LD: begin
        u.acc_op  = ACC_LOAD;
        u.mul_sel = MUL_INT_KI;
      end
      ST_ACC_ADD: begin
        u.acc_op = ACC_ADD;
      end
      ST_DRV: begin
        u.drv_ld   = 1'b1;
        u.use_bias = 1'b1;
      end
      ST_SPD: begin
        u.mul_sel = MUL_SPD_OLG;
        u.jmp     = JMP_NO_SPD;
        u.jmp_tgt = ST_DONE;
      end
      ST_SPD_LD: begin
        u.acc_op = ACC_LOAD;
      end
      ST_SPD_DRV: begin
        u.drv_ld = 1'b1;
      end
      ST_DONE: begin
        u.done = 1'b1;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### src/mapi_dp.sv
// datapath: request latches, shared multiplier, accumulator, saturation and integral store
// depends on mapi_pkg; driven by the control word of the top level sequencer
`default_nettype none

module mapi_dp (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire mapi_pkg::ucode_t   uc_i,
  input  wire mapi_pkg::cfg_t     cfg_i,
  input  wire  [2:0]              axis_i,
  input  wire                     position_active_i,
  input  wire  [31:0]             position_setpoint_i,
  input  wire  [31:0]             position_estimate_i,
  input  wire                     speed_active_i,
  input  wire  [31:0]             speed_setpoint_i,
  output mapi_pkg::dp_stat_t      stat_o
);
  import mapi_pkg::*;

  logic [AXIS_W-1:0]        axis_q;
  logic                     pos_q;
  logic                     spd_on_q;
  logic signed [DATA_W-1:0] sp_q;
  logic signed [DATA_W-1:0] est_q;
  logic signed [DATA_W-1:0] spd_q;

  logic signed [DATA_W-1:0] err_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DATA_W-1:0]        drive_q;
  logic                     sat_q;
  logic signed [DATA_W-1:0] integ_q [NUM_AXES];

  logic                     axis_ok;
  logic                     pos_eff;
  logic                     spd_eff;
  logic [AXIS_IDX_W-1:0]    idx;
  logic signed [DATA_W-1:0] integ_rd;
  logic signed [OPND_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  diff;
  logic signed [ACC_W-1:0]  integ_sum;
  logic signed [ACC_W-1:0]  drv_sum;
  clip_t                    err_clip;
  clip_t                    integ_clip;
  clip_t                    drv_clip;

  assign axis_ok  = {1'b0, axis_q} < (AXIS_W + 1)'(NUM_AXES);
  assign pos_eff  = axis_ok && pos_q;
  assign spd_eff  = axis_ok && spd_on_q &&
                    (axis_q == AXIS_X || axis_q == AXIS_Y || axis_q == AXIS_YAW);
  assign idx      = axis_q[AXIS_IDX_W-1:0];
  assign integ_rd = integ_q[idx];

  // operand select for the shared multiplier
  always_comb begin
    case (uc_i.mul_sel)
      MUL_ERR_DT: begin
        mul_a = OPND_W'(err_q);
        mul_b = $signed({{(OPND_W-DT_W){1'b0}}, cfg_i.dt});
      end
      MUL_ERR_KP: begin
        mul_a = OPND_W'(err_q);
        mul_b = $signed({1'b0, cfg_i.kp});
      end
      MUL_INT_KI: begin
        mul_a = OPND_W'(integ_rd);
        mul_b = $signed({1'b0, cfg_i.ki});
      end
      MUL_SPD_OLG: begin
        mul_a = OPND_W'(spd_q);
        mul_b = $signed({1'b0, cfg_i.olg});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round to nearest, ties up, then drop the fraction
  assign rounded = prod_q + ROUND_HALF;
  assign shifted = rounded >>> FRAC_BITS;
  assign scaled  = shifted[ACC_W-1:0];

  assign diff      = ACC_W'(sp_q) - ACC_W'(est_q);
  assign err_clip  = clip32(diff);
  assign integ_sum = ACC_W'(integ_rd) + scaled;
  assign integ_clip = clip32(integ_sum);
  assign drv_sum   = acc_q + ((uc_i.use_bias && axis_q == AXIS_Z) ?
                              ACC_W'($signed(cfg_i.bias)) : ACC_W'(0));
  assign drv_clip  = clip32(drv_sum);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      axis_q   <= axis_i;
      pos_q    <= position_active_i;
      spd_on_q <= speed_active_i;
      sp_q     <= position_setpoint_i;
      est_q    <= position_estimate_i;
      spd_q    <= speed_setpoint_i;
    end
    prod_q <= mul_a * mul_b;
    if (uc_i.err_ld) begin
      err_q <= err_clip.val;
    end
    case (uc_i.acc_op)
      ACC_LOAD: acc_q <= scaled;
      ACC_ADD:  acc_q <= acc_q + scaled;
      default:  acc_q <= acc_q;
    endcase
    if (start_i) begin
      drive_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (uc_i.drv_ld) begin
        drive_q <= drv_clip.val;
      end
      if ((uc_i.err_ld && pos_eff && err_clip.sat) ||
          (uc_i.integ_wr && integ_clip.sat) ||
          (uc_i.drv_ld && drv_clip.sat)) begin
        sat_q <= 1'b1;
      end
    end
  end

  // integral store, one entry per axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        integ_q[i] <= '0;
      end
    end else if (uc_i.integ_wr && pos_eff) begin
      integ_q[idx] <= integ_clip.val;
    end
  end

  assign stat_o.pos_eff = pos_eff;
  assign stat_o.spd_eff = spd_eff;
  assign stat_o.axis    = axis_q;
  assign stat_o.drive   = drive_q;
  assign stat_o.sat     = sat_q;

endmodule

`default_nettype wire

### src/multi_axis_pi_wrench_controller.sv
// top level of the five-axis pi wrench controller: apb registers, microcode sequencer,
// output register; depends on mapi_pkg and mapi_dp
//
//  channel  handshake                 payload
//  in       in_valid_i / in_stall_o   axis_i, position_active_i, position_setpoint_i,
//                                     position_estimate_i, speed_active_i, speed_setpoint_i
//  out      out_valid_o / out_stall_i axis_out_o, drive_o, saturated_o
//  cfg      psel/penable/pwrite/pready paddr[4:2] selects kp, ki, dt, olg, bias
//
// a request occupies the sequencer from acceptance until its program is done; the program
// length depends on the active modes, as the position part and the speed part are each
// skipped when not in effect; the next request is taken once the sequencer is free, and
// the steps run one after another through the single shared multiplier
// reset clears the sequencer, the output valid, the registers to their defaults and
// every axis integral
// in_stall_o is high while a request is in the sequencer; a stalled output only holds
// the final step, a waiting result does not block the next request
`default_nettype none

module multi_axis_pi_wrench_controller (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  axis_i,
  input  wire         position_active_i,
  input  wire  [31:0] position_setpoint_i,
  input  wire  [31:0] position_estimate_i,
  input  wire         speed_active_i,
  input  wire  [31:0] speed_setpoint_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  axis_out_o,
  output logic [31:0] drive_o,
  output logic        saturated_o,
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mapi_pkg::*;

  // configuration registers
  logic [DATA_W-1:0] kp_q;
  logic [DATA_W-1:0] ki_q;
  logic [DT_W-1:0]   dt_q;
  logic [DATA_W-1:0] olg_q;
  logic [DATA_W-1:0] bias_q;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  cfg_t              cfg;

  // sequencer
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  ucode_t            uc;
  ucode_t            uc_dp;
  logic              accept;
  logic              out_free;
  logic              jump;
  logic              finish;
  dp_stat_t          stat;

  // result register
  logic              out_valid_q;
  logic [AXIS_W-1:0] axis_out_q;
  logic [DATA_W-1:0] drive_out_q;
  logic              sat_out_q;

  // register port, always ready
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KP_RST;
      ki_q   <= KI_RST;
      dt_q   <= DT_RST;
      olg_q  <= OLG_RST;
      bias_q <= BIAS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KP:   kp_q   <= pwdata;
        REG_KI:   ki_q   <= pwdata;
        REG_DT:   dt_q   <= pwdata[DT_W-1:0];
        REG_OLG:  olg_q  <= pwdata;
        REG_BIAS: bias_q <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KP:   prdata = kp_q;
      REG_KI:   prdata = ki_q;
      REG_DT:   prdata = {{(DATA_W-DT_W){1'b0}}, dt_q};
      REG_OLG:  prdata = olg_q;
      REG_BIAS: prdata = bias_q;
      default:  prdata = '0;
    endcase
  end

  assign cfg.kp   = kp_q;
  assign cfg.ki   = ki_q;
  assign cfg.dt   = dt_q;
  assign cfg.olg  = olg_q;
  assign cfg.bias = bias_q;

  // control word of the current step; idle cycles issue a blank word
  assign uc    = ucode_rom(step_q);
  assign uc_dp = busy_q ? uc : '0;

  assign accept   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = busy_q && uc.done && out_free;

  // conditional jumps skip the position or the speed part of the program
  always_comb begin
    case (uc.jmp)
      JMP_NO_POS: jump = !stat.pos_eff;
      JMP_NO_SPD: jump = !stat.spd_eff;
      default:    jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= ST_ERR;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= ST_ERR;
      end else if (busy_q) begin
        if (uc.done) begin
          // hold the last step until the result register frees up
          if (out_free) begin
            busy_q <= 1'b0;
          end
        end else if (jump) begin
          step_q <= uc.jmp_tgt;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      axis_out_q  <= stat.axis;
      drive_out_q <= stat.drive;
      sat_out_q   <= stat.sat;
    end
  end

  mapi_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (accept),
    .uc_i                (uc_dp),
    .cfg_i               (cfg),
    .axis_i              (axis_i),
    .position_active_i   (position_active_i),
    .position_setpoint_i (position_setpoint_i),
    .position_estimate_i (position_estimate_i),
    .speed_active_i      (speed_active_i),
    .speed_setpoint_i    (speed_setpoint_i),
    .stat_o              (stat)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign axis_out_o  = axis_out_q;
  assign drive_o     = drive_out_q;
  assign saturated_o = sat_out_q;

  // a taken request always starts the program at its first step
  a_start_at_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && step_q == ST_ERR)
    else $error("request did not start at the first step");

  // finishing frees the sequencer and presents the result
  a_finish_hands_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> !busy_q && out_valid_o)
    else $error("finished request not handed to the result register");

  // an axis outside the range gives a zero drive and no saturation
  a_bad_axis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && {1'b0, axis_out_o} >= (AXIS_W + 1)'(NUM_AXES)) |->
      (drive_o == '0 && !saturated_o))
    else $error("out of range axis produced a drive");

endmodule

`default_nettype wire
